// ----- src/fpn_pkg.sv -----
// Shared types, widths and register codes of the frame power normalizer.
// No dependencies; every other file of the block imports this package.
package fpn_pkg;

  parameter int DEF_MAX_SAMPLES  = 4096;
  parameter int DEF_MAX_ANTENNAS = 2;

  parameter int SAMPLE_W   = 16;
  parameter int OUT_W      = 40;
  parameter int GAIN_W     = 40;
  parameter int ENERGY_W   = 46;
  parameter int AMP_W      = 32;
  parameter int LEN_W      = 13;
  parameter int START_W    = 12;
  parameter int ANT_W      = 2;
  parameter int BITS_W     = 5;
  parameter int CFG_IDX_W  = 3;
  parameter int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START     = 3'd0,
    REG_WINDOW_LENGTH    = 3'd1,
    REG_ANTENNA_COUNT    = 3'd2,
    REG_SAMPLE_BITS      = 3'd3,
    REG_TARGET_AMPLITUDE = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic                start;
    logic [ENERGY_W-1:0] energy;
    logic [AMP_W-1:0]    amp;
    logic [LEN_W-1:0]    len;
    logic [BITS_W-1:0]   bits;
  } gain_req_t;

  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] gain;
  } gain_stat_t;

endpackage

// ----- src/fpn_if.sv -----
// Request channel interfaces of the frame power normalizer.
// Depends on fpn_pkg for the field widths.
interface fpn_in_if;
  import fpn_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [SAMPLE_W-1:0] re0;
  logic signed [SAMPLE_W-1:0] im0;
  logic signed [SAMPLE_W-1:0] re1;
  logic signed [SAMPLE_W-1:0] im1;
  logic                       frame_end;
  modport source(output valid, operation, re0, im0, re1, im1, frame_end, input ready);
  modport sink(input valid, operation, re0, im0, re1, im1, frame_end, output ready);
endinterface

interface fpn_out_if;
  import fpn_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_re0;
  logic signed [OUT_W-1:0] out_im0;
  logic signed [OUT_W-1:0] out_re1;
  logic signed [OUT_W-1:0] out_im1;
  logic                    run_end;
  logic                    clipped;
  modport source(output valid, out_re0, out_im0, out_re1, out_im1, run_end, clipped,
                 input ready);
  modport sink(input valid, out_re0, out_im0, out_re1, out_im1, run_end, clipped,
               output ready);
endinterface

// ----- src/fpn_gain.sv -----
// Frame gain unit: bit-serial search for the largest g with g^2*E <= A^2*L; zero energy gives the unit gain.
// Depends on fpn_pkg for the request and status structs.
module fpn_gain (
  input  logic                   clk,
  input  logic                   rst,
  input  fpn_pkg::gain_req_t     req,
  output fpn_pkg::gain_stat_t    stat
);
  import fpn_pkg::*;

  localparam int ACC_W     = 128;
  localparam int ACC_SHIFT = 2 * (GAIN_W - 1);
  localparam int SQ_W      = 2 * AMP_W;
  localparam int RHS_W     = SQ_W + LEN_W;
  localparam int K_W       = $clog2(GAIN_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQR  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_CAND = 5'b01000,
    ST_CMP  = 5'b10000
  } gstate_t;

  gstate_t             state;
  logic [ENERGY_W-1:0] energy;
  logic [AMP_W-1:0]    amp;
  logic [LEN_W-1:0]    len;
  logic [SQ_W-1:0]     amp_sq;
  logic [RHS_W-1:0]    rhs;
  logic [ACC_W-1:0]    ek;
  logic [ACC_W-1:0]    pk;
  logic [ACC_W-1:0]    s_acc;
  logic [ACC_W-1:0]    cand;
  logic [GAIN_W-1:0]   gain;
  logic [K_W-1:0]      bitk;
  logic                cand_ok;
  logic [ACC_W-1:0]    pk_add;
  logic [BITS_W-1:0]   bits_c;
  logic [GAIN_W-1:0]   unit_gain;

  assign cand_ok = cand <= ACC_W'(rhs);
  assign pk_add  = pk + (ek << 1);

  always_comb begin
    if (req.bits == '0) begin
      bits_c = BITS_W'(1);
    end else if (req.bits > BITS_W'(16)) begin
      bits_c = BITS_W'(16);
    end else begin
      bits_c = req.bits;
    end
    unit_gain = GAIN_W'(1) << (BITS_W'(25) - bits_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      gain  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.start) begin
            if (req.energy == '0) begin
              gain <= unit_gain;
            end else begin
              energy <= req.energy;
              amp    <= req.amp;
              len    <= req.len;
              state  <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          amp_sq <= SQ_W'(amp) * SQ_W'(amp);
          state  <= ST_MUL;
        end
        ST_MUL: begin
          rhs   <= RHS_W'(amp_sq) * RHS_W'(len);
          ek    <= ACC_W'(energy) << ACC_SHIFT;
          pk    <= '0;
          s_acc <= '0;
          gain  <= '0;
          bitk  <= K_W'(GAIN_W - 1);
          state <= ST_CAND;
        end
        ST_CAND: begin
          cand  <= s_acc + pk + ek;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (cand_ok) begin
            s_acc      <= cand;
            gain[bitk] <= 1'b1;
            pk         <= pk_add >> 1;
          end else begin
            pk <= pk >> 1;
          end
          ek <= ek >> 2;
          if (bitk == '0) begin
            state <= ST_IDLE;
          end else begin
            bitk  <= bitk - K_W'(1);
            state <= ST_CAND;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.busy = state != ST_IDLE;
  assign stat.gain = gain;

endmodule

// ----- src/fpn_lane.sv -----
// One scaling lane: multiplies a sample by the frame gain and saturates.
// Depends on fpn_pkg for the widths.
module fpn_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [fpn_pkg::SAMPLE_W-1:0] sample,
  input  logic [fpn_pkg::GAIN_W-1:0]          gain,
  output logic signed [fpn_pkg::OUT_W-1:0]    result,
  output logic                                clip
);
  import fpn_pkg::*;

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic                     ovf;
  logic signed [OUT_W-1:0]  sat;

  always_comb begin
    ovf = !((&prod[PROD_W-1:OUT_W-1]) || !(|prod[PROD_W-1:OUT_W-1]));
    if (!ovf) begin
      sat = prod[OUT_W-1:0];
    end else if (prod[PROD_W-1]) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= PROD_W'(sample) * $signed({1'b0, gain});
      result <= sat;
      clip   <= ovf;
    end
  end

endmodule

// ----- src/frame_power_normalizer.sv -----
// Channel   | Dir | Payload
// in_ch     | in  | operation, re0, im0, re1, im1, frame_end
// out_ch    | out | out_re0, out_im0, out_re1, out_im1, run_end, clipped
// cfg_*     | in  | cfg_write, cfg_index, cfg_data
// Drains stream one per cycle unless the output stalls, via read, product and result registers.
// A closing load starts the gain search (square, multiply, then candidate and compare per gain
// bit, in the 128-bit compare unit; zero energy skips it); the input is not ready meanwhile.
// Reset is synchronous and clears control state only; the sample memory needs no clear.
// A stalled output freezes the whole drain pipeline and holds the input off.
// Top level of the frame power normalizer; depends on fpn_pkg, fpn_if, fpn_gain, fpn_lane.
module frame_power_normalizer #(
  parameter int MAX_SAMPLES  = fpn_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_ANTENNAS = fpn_pkg::DEF_MAX_ANTENNAS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fpn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpn_pkg::CFG_DATA_W-1:0]   cfg_data,
  fpn_in_if.sink                           in_ch,
  fpn_out_if.source                        out_ch
);
  import fpn_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int WIN_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int NLANE  = 2 * MAX_ANTENNAS;
  localparam int WORD_W = 4 * SAMPLE_W;
  localparam int POW_W  = 2 * SAMPLE_W + 1;

  logic [START_W-1:0] window_start;
  logic [LEN_W-1:0]   window_length;
  logic [ANT_W-1:0]   antenna_count;
  logic [BITS_W-1:0]  sample_bits;
  logic [AMP_W-1:0]   target_amplitude;

  logic [CNT_W-1:0]    load_count;
  logic [CNT_W-1:0]    drain_index;
  logic                frame_ready;
  logic [ENERGY_W-1:0] energy;
  logic [ENERGY_W-1:0] energy_next;

  logic [WORD_W-1:0] mem [MAX_SAMPLES];
  logic [WORD_W-1:0] rd_data;

  logic advance, accept, do_load, is_drain, store_ok, in_window, two_ant, last;
  logic signed [2*SAMPLE_W-1:0] sq_re0, sq_im0, sq_re1, sq_im1;
  logic [POW_W-1:0]    power;
  logic [ENERGY_W:0]   energy_sum;
  logic [WIN_W-1:0]    idx_w, start_w, stop_w;

  gain_req_t  greq;
  gain_stat_t gstat;

  logic v1, end1, two1, v2, end2, out_valid, out_end;
  logic signed [SAMPLE_W-1:0] lane_sample [NLANE];
  logic signed [OUT_W-1:0]    lane_res [NLANE];
  logic [NLANE-1:0]           lane_clip;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = advance && !gstat.busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign do_load     = accept && (in_ch.operation == OP_LOAD) && !frame_ready;
  assign is_drain    = accept && (in_ch.operation == OP_DRAIN) && frame_ready;
  assign store_ok    = load_count < CNT_W'(MAX_SAMPLES);
  assign two_ant     = antenna_count[1] && (MAX_ANTENNAS > 1);
  assign last        = (drain_index + CNT_W'(1)) >= load_count;

  assign idx_w     = WIN_W'(load_count);
  assign start_w   = WIN_W'(window_start);
  assign stop_w    = WIN_W'(window_start) + WIN_W'(window_length);
  assign in_window = (idx_w >= start_w) && (idx_w < stop_w);

  always_comb begin
    sq_re0 = in_ch.re0 * in_ch.re0;
    sq_im0 = in_ch.im0 * in_ch.im0;
    sq_re1 = in_ch.re1 * in_ch.re1;
    sq_im1 = in_ch.im1 * in_ch.im1;
    power  = POW_W'(unsigned'(sq_re0)) + POW_W'(unsigned'(sq_im0));
    if (two_ant) begin
      power = power + POW_W'(unsigned'(sq_re1)) + POW_W'(unsigned'(sq_im1));
    end
    energy_sum  = (ENERGY_W + 1)'(energy) + (ENERGY_W + 1)'(power);
    energy_next = energy;
    if (do_load && store_ok && in_window) begin
      energy_next = energy_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_sum[ENERGY_W-1:0];
    end
  end

  assign greq.start  = do_load && in_ch.frame_end;
  assign greq.energy = energy_next;
  assign greq.amp    = target_amplitude;
  assign greq.len    = window_length;
  assign greq.bits   = sample_bits;

  fpn_gain u_gain (
    .clk  (clk),
    .rst  (rst),
    .req  (greq),
    .stat (gstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start     <= '0;
      window_length    <= LEN_W'(1);
      antenna_count    <= ANT_W'(1);
      sample_bits      <= BITS_W'(16);
      target_amplitude <= AMP_W'(32'h0100_0000);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_START:     window_start     <= cfg_data[START_W-1:0];
        REG_WINDOW_LENGTH:    window_length    <= cfg_data[LEN_W-1:0];
        REG_ANTENNA_COUNT:    antenna_count    <= cfg_data[ANT_W-1:0];
        REG_SAMPLE_BITS:      sample_bits      <= cfg_data[BITS_W-1:0];
        REG_TARGET_AMPLITUDE: target_amplitude <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count  <= '0;
      drain_index <= '0;
      frame_ready <= 1'b0;
      energy      <= '0;
    end else if (do_load) begin
      energy <= energy_next;
      if (store_ok) begin
        load_count <= load_count + CNT_W'(1);
      end
      if (in_ch.frame_end) begin
        frame_ready <= 1'b1;
        drain_index <= '0;
      end
    end else if (is_drain) begin
      if (last) begin
        frame_ready <= 1'b0;
        load_count  <= '0;
        drain_index <= '0;
        energy      <= '0;
      end else begin
        drain_index <= drain_index + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load && store_ok) begin
      mem[load_count[IDX_W-1:0]] <= {in_ch.im1, in_ch.re1, in_ch.im0, in_ch.re0};
    end
    if (is_drain) begin
      rd_data <= mem[drain_index[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= is_drain;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      end1    <= last;
      two1    <= two_ant;
      end2    <= end1;
      out_end <= end2;
    end
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    assign lane_sample[i] = (i < 2 || two1) ? $signed(rd_data[SAMPLE_W*i +: SAMPLE_W]) : '0;
    fpn_lane u_lane (
      .clk    (clk),
      .en     (advance),
      .sample (lane_sample[i]),
      .gain   (gstat.gain),
      .result (lane_res[i]),
      .clip   (lane_clip[i])
    );
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.run_end = out_end;
  assign out_ch.clipped = |lane_clip;
  assign out_ch.out_re0 = lane_res[0];
  assign out_ch.out_im0 = lane_res[1];

  if (MAX_ANTENNAS > 1) begin : g_two
    assign out_ch.out_re1 = lane_res[2];
    assign out_ch.out_im1 = lane_res[3];
  end else begin : g_one
    assign out_ch.out_re1 = '0;
    assign out_ch.out_im1 = '0;
  end

endmodule

// ----- src/fpn_check.sv -----
// Port-level checker of the frame power normalizer, bound to the top level.
// Depends on fpn_pkg for widths and on frame_power_normalizer for the bind.
module fpn_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [fpn_pkg::OUT_W-1:0] out_re0,
  input logic                             run_end
);
  import fpn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_re0) && $stable(run_end))
    else $error("result payload changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready while the output is stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result request present right after reset");

endmodule

bind frame_power_normalizer fpn_check u_fpn_check (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_re0      (out_ch.out_re0),
  .run_end      (out_ch.run_end)
);

// ----- tb/frame_power_normalizer_test.sv -----
// Self-checking testbench of frame_power_normalizer: directed and random frames of load and drain requests
// are checked against a built-in model of energy, gain search and saturating scaling.
// Depends on fpn_pkg, fpn_if and the frame_power_normalizer RTL.
`timescale 1ns / 1ps

module frame_power_normalizer_test;
  import fpn_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_SAMPLES;
  localparam longint ENERGY_MAX = (64'sd1 <<< ENERGY_W) - 1;
  localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

  typedef struct {
    op_t                 op;
    logic signed [15:0]  re0, im0, re1, im1;
    logic                fe;
  } sample_req_t;

  typedef struct {
    logic [OUT_W-1:0] re0, im0, re1, im1;
    logic             run_end;
    logic             clipped;
  } scaled_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fpn_in_if  in_if();
  fpn_out_if out_if();

  frame_power_normalizer dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_if), .out_ch(out_if)
  );

  sample_req_t pending_reqs[$];
  scaled_t     expected_samples[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          req_taken = 1'b0;
  int          errors = 0;

  // Model state and registers.
  logic [11:0] m_start = 12'd0;
  logic [12:0] m_length = 13'd1;
  logic [1:0]  m_ants = 2'd1;
  logic [4:0]  m_bits = 5'd16;
  logic [31:0] m_amp = 32'd16777216;
  logic [63:0] m_store[STORE_DEPTH];
  longint      m_energy = 0;
  int          m_loaded = 0;
  int          m_drained = 0;
  bit          m_ready = 1'b0;
  logic [GAIN_W-1:0] m_gain = '0;

  initial forever #5 clk = ~clk;

  function automatic int active_ants();
    int n;
    n = m_ants;
    if (n < 1) n = 1;
    if (n > 2) n = 2;
    if (n > DEF_MAX_ANTENNAS) n = DEF_MAX_ANTENNAS;
    return n;
  endfunction

  function automatic logic [GAIN_W-1:0] search_gain();
    logic [127:0] bound;
    logic [127:0] trial_sq;
    logic [GAIN_W-1:0] g;
    logic [GAIN_W-1:0] t;
    int b;
    if (m_energy == 0) begin
      b = m_bits;
      if (b < 1) b = 1;
      if (b > 16) b = 16;
      return GAIN_W'(1) << (25 - b);
    end
    bound = 128'(m_amp) * 128'(m_amp) * 128'(m_length);
    g = '0;
    for (int k = GAIN_W - 1; k >= 0; k--) begin
      t = g | (GAIN_W'(1) << k);
      trial_sq = 128'(t) * 128'(t) * 128'(m_energy);
      if (trial_sq <= bound) g = t;
    end
    return g;
  endfunction

  function automatic logic [OUT_W-1:0] scale_component(logic signed [15:0] x, ref bit clip);
    longint v;
    v = longint'(x) * longint'(m_gain);
    if (v > OUT_MAX) begin
      v = OUT_MAX;
      clip = 1'b1;
    end
    if (v < OUT_MIN) begin
      v = OUT_MIN;
      clip = 1'b1;
    end
    return v[OUT_W-1:0];
  endfunction

  task automatic normalize_request(sample_req_t r);
    scaled_t s;
    logic [63:0] w;
    bit clip;
    longint re, im;
    if (r.op == OP_LOAD) begin
      if (m_ready) return;
      if (m_loaded < STORE_DEPTH) begin
        m_store[m_loaded] = {r.im1, r.re1, r.im0, r.re0};
        if (m_loaded >= int'(m_start) && m_loaded < int'(m_start) + int'(m_length)) begin
          for (int a = 0; a < active_ants(); a++) begin
            re = (a == 0) ? longint'(r.re0) : longint'(r.re1);
            im = (a == 0) ? longint'(r.im0) : longint'(r.im1);
            m_energy = m_energy + re * re + im * im;
            if (m_energy > ENERGY_MAX) m_energy = ENERGY_MAX;
          end
        end
        m_loaded++;
      end
      if (r.fe) begin
        m_gain = search_gain();
        m_ready = 1'b1;
        m_drained = 0;
      end
      return;
    end
    if (!m_ready) return;
    w = m_store[m_drained];
    clip = 1'b0;
    s.re0 = scale_component(w[15:0], clip);
    s.im0 = scale_component(w[31:16], clip);
    if (active_ants() == 2) begin
      s.re1 = scale_component(w[47:32], clip);
      s.im1 = scale_component(w[63:48], clip);
    end else begin
      s.re1 = '0;
      s.im1 = '0;
    end
    m_drained++;
    s.run_end = 1'b0;
    if (m_drained >= m_loaded) begin
      s.run_end = 1'b1;
      m_ready = 1'b0;
      m_loaded = 0;
      m_drained = 0;
      m_energy = 0;
    end
    s.clipped = clip;
    expected_samples.push_back(s);
  endtask

  // Monitor: register writes, accepted requests and results.
  always @(posedge clk) begin
    scaled_t e;
    sample_req_t r;
    if (!rst && cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_START:     m_start = cfg_data[11:0];
        REG_WINDOW_LENGTH:    m_length = cfg_data[12:0];
        REG_ANTENNA_COUNT:    m_ants = cfg_data[1:0];
        REG_SAMPLE_BITS:      m_bits = cfg_data[4:0];
        REG_TARGET_AMPLITUDE: m_amp = cfg_data;
        default: ;
      endcase
    end
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result re0=%h", out_if.out_re0);
        errors++;
      end else begin
        e = expected_samples.pop_front();
        if (out_if.out_re0 !== e.re0) begin
          $error("out_re0 expected %h got %h", e.re0, out_if.out_re0); errors++;
        end
        if (out_if.out_im0 !== e.im0) begin
          $error("out_im0 expected %h got %h", e.im0, out_if.out_im0); errors++;
        end
        if (out_if.out_re1 !== e.re1) begin
          $error("out_re1 expected %h got %h", e.re1, out_if.out_re1); errors++;
        end
        if (out_if.out_im1 !== e.im1) begin
          $error("out_im1 expected %h got %h", e.im1, out_if.out_im1); errors++;
        end
        if (out_if.run_end !== e.run_end) begin
          $error("run_end expected %b got %b", e.run_end, out_if.run_end); errors++;
        end
        if (out_if.clipped !== e.clipped) begin
          $error("clipped expected %b got %b", e.clipped, out_if.clipped); errors++;
        end
      end
    end
    req_taken <= !rst && in_if.valid && in_if.ready;
    if (!rst && in_if.valid && in_if.ready) begin
      r.op = op_t'(in_if.operation);
      r.re0 = in_if.re0;
      r.im0 = in_if.im0;
      r.re1 = in_if.re1;
      r.im1 = in_if.im1;
      r.fe = in_if.frame_end;
      normalize_request(r);
    end
  end

  // Driver: request channel and result back-pressure.
  always @(negedge clk) begin
    sample_req_t r;
    if (rst) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_if.valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          in_if.operation <= r.op;
          in_if.re0 <= r.re0;
          in_if.im0 <= r.im0;
          in_if.re1 <= r.re1;
          in_if.im1 <= r.im1;
          in_if.frame_end <= r.fe;
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_req(op_t op, bit fe, logic signed [15:0] a, logic signed [15:0] b,
                          logic signed [15:0] c, logic signed [15:0] d);
    sample_req_t r;
    r.op = op; r.fe = fe; r.re0 = a; r.im0 = b; r.re1 = c; r.im1 = d;
    pending_reqs.push_back(r);
  endtask

  task automatic push_frame(int n, bit noisy);
    int stored;
    for (int i = 0; i < n; i++)
      push_req(OP_LOAD, i == n - 1, rand_sample(), rand_sample(), rand_sample(), rand_sample());
    stored = (n < STORE_DEPTH) ? n : STORE_DEPTH;
    for (int j = 0; j < stored; j++) begin
      if (noisy && $urandom_range(9) == 0)
        push_req(OP_LOAD, 1'($urandom), rand_sample(), rand_sample(), rand_sample(),
                 rand_sample());
      push_req(OP_DRAIN, 1'($urandom), rand_sample(), rand_sample(), rand_sample(),
               rand_sample());
    end
    if (noisy && $urandom_range(3) == 0)
      push_req(OP_DRAIN, 1'($urandom), rand_sample(), rand_sample(), rand_sample(),
               rand_sample());
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_if.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] ws, logic [CFG_DATA_W-1:0] wl,
                           logic [CFG_DATA_W-1:0] ac, logic [CFG_DATA_W-1:0] sb,
                           logic [CFG_DATA_W-1:0] amp);
    write_reg(REG_WINDOW_START, ws);
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_ANTENNA_COUNT, ac);
    write_reg(REG_SAMPLE_BITS, sb);
    write_reg(REG_TARGET_AMPLITUDE, amp);
  endtask

  task automatic write_random_cfg();
    logic [31:0] ws, wl, amp;
    ws = ($urandom_range(9) == 0) ? 32'hfff : $urandom_range(20);
    case ($urandom_range(9))
      0: wl = 0;
      1: wl = 4096;
      2: wl = 13'h1fff;
      default: wl = $urandom_range(1, 40);
    endcase
    case ($urandom_range(7))
      0: amp = 0;
      1: amp = 32'hffffffff;
      2: amp = 32'h01000000;
      default: amp = $urandom;
    endcase
    write_all(ws, wl, $urandom_range(3), $urandom_range(31), amp);
  endtask

  initial begin
    int pushed;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.operation = 1'b0;
    in_if.re0 = '0;
    in_if.im0 = '0;
    in_if.re1 = '0;
    in_if.im1 = '0;
    in_if.frame_end = 1'b0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: drain with no frame, extreme samples, two antennas, load while ready,
    // empty window and an out-of-range window.
    push_req(OP_DRAIN, 1'b0, 16'sh7fff, 0, 0, 0);
    push_req(OP_LOAD, 1'b0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    push_req(OP_LOAD, 1'b1, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff);
    push_req(OP_DRAIN, 1'b0, 0, 0, 0, 0);
    push_req(OP_LOAD, 1'b1, 16'sh1234, 0, 0, 0);
    push_req(OP_DRAIN, 1'b0, 0, 0, 0, 0);
    wait_drained();
    write_all(0, 2, 2, 1, 32'hffffffff);
    push_req(OP_LOAD, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_req(OP_LOAD, 1'b1, 16'sh0001, 16'sh0000, 16'sh7fff, 16'sh0003);
    push_req(OP_DRAIN, 1'b0, 0, 0, 0, 0);
    push_req(OP_DRAIN, 1'b1, 0, 0, 0, 0);
    wait_drained();
    write_all(0, 0, 3, 0, 32'h01000000);
    push_req(OP_LOAD, 1'b0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    push_req(OP_LOAD, 1'b1, 16'sh4000, 16'shc000, 16'sh0000, 16'sh0000);
    push_req(OP_DRAIN, 1'b0, 0, 0, 0, 0);
    push_req(OP_DRAIN, 1'b0, 0, 0, 0, 0);
    wait_drained();
    write_all(32'hfff, 4096, 0, 31, 0);
    push_req(OP_LOAD, 1'b1, 16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400);
    push_req(OP_DRAIN, 1'b0, 0, 0, 0, 0);
    wait_drained();

    // Random phases with different idling; the store-full frame runs once.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 0) begin
        write_all(0, 4096, 2, 16, 32'h00800000);
        push_frame(STORE_DEPTH + 3, 1'b0);
        wait_drained();
      end
      pushed = 0;
      while (pushed < 170) begin
        write_random_cfg();
        for (int f = 0; f < 4; f++) begin
          int n;
          n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
          push_frame(n, $urandom_range(3) == 0);
          pushed += 2 * n;
          if ($urandom_range(4) == 0) begin
            while (pending_reqs.size() != 0 || in_if.valid) @(posedge clk);
            while (expected_samples.size() != 0) @(posedge clk);
          end
        end
        wait_drained();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("frame_power_normalizer test passed");
    end else begin
      $display("frame_power_normalizer test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("frame_power_normalizer test failed");
    $finish;
  end

endmodule
